### hw/rtl/hrhc_pkg.sv
package hrhc_pkg;

	// Default limits on line and header size.
	localparam int unsigned MAX_LINE_DEF   = 255;
	localparam int unsigned MAX_HEADER_DEF = 2048;

	// Widths fixed by the register and field definitions.
	localparam int unsigned LEN_W     = 24;
	localparam int unsigned VERDICT_W = 2;

	// Verdict codes.
	localparam logic [VERDICT_W-1:0] V_BUSY   = 2'd0;
	localparam logic [VERDICT_W-1:0] V_ACCEPT = 2'd1;
	localparam logic [VERDICT_W-1:0] V_REJECT = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_EXPECTED = 1'b0;
	localparam logic CFG_LIMIT    = 1'b1;

	// Character codes.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UPA   = 8'h41;
	localparam logic [7:0] CH_UPZ   = 8'h5A;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// Status line pattern; the minor version digit is checked on its own.
	localparam logic [8*13-1:0] STATUS_PAT = "HTTP/1.x 200 ";
	localparam logic [8*17-1:0] NAME_TE    = "transfer-encoding";
	localparam logic [8*16-1:0] NAME_CE    = "content-encoding";
	localparam logic [8*14-1:0] NAME_CL    = "content-length";

	// Character of the status pattern at a position of 0 to 12.
	function automatic logic [7:0] status_at(input logic [3:0] pos);
		logic [7:0] ch;
		ch = CH_NUL;
		if (pos <= 4'd12) begin
			ch = STATUS_PAT[8*(12 - int'(pos)) +: 8];
		end
		return ch;
	endfunction

	// Characters of the watched header names; NUL past the end never matches.
	function automatic logic [7:0] te_at(input logic [4:0] pos);
		logic [7:0] ch;
		ch = CH_NUL;
		if (pos < 5'd17) begin
			ch = NAME_TE[8*(16 - int'(pos)) +: 8];
		end
		return ch;
	endfunction

	function automatic logic [7:0] ce_at(input logic [4:0] pos);
		logic [7:0] ch;
		ch = CH_NUL;
		if (pos < 5'd16) begin
			ch = NAME_CE[8*(15 - int'(pos)) +: 8];
		end
		return ch;
	endfunction

	function automatic logic [7:0] cl_at(input logic [4:0] pos);
		logic [7:0] ch;
		ch = CH_NUL;
		if (pos < 5'd14) begin
			ch = NAME_CL[8*(13 - int'(pos)) +: 8];
		end
		return ch;
	endfunction

endpackage

### hw/rtl/hrhc_core.sv
module hrhc_core #(
	parameter int unsigned MAX_LINE   = hrhc_pkg::MAX_LINE_DEF,
	parameter int unsigned MAX_HEADER = hrhc_pkg::MAX_HEADER_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step_en,
	input  logic                            restart,
	input  logic [7:0]                      data_byte,
	input  logic [hrhc_pkg::LEN_W-1:0]      expected_length,
	input  logic [hrhc_pkg::LEN_W-1:0]      length_limit,
	output logic [hrhc_pkg::VERDICT_W-1:0]  verdict_cur,
	output logic [hrhc_pkg::VERDICT_W-1:0]  verdict_next
);

	localparam int unsigned LINE_W = $clog2(MAX_LINE + 1);
	localparam int unsigned TOT_W  = $clog2(MAX_HEADER + 2);
	localparam int unsigned PROD_W = hrhc_pkg::LEN_W + 4;

	// Parse phases.
	localparam logic [3:0] PH_STATUS  = 4'd0;
	localparam logic [3:0] PH_NAME    = 4'd1;
	localparam logic [3:0] PH_OTHER   = 4'd2;
	localparam logic [3:0] PH_CL_LEAD = 4'd3;
	localparam logic [3:0] PH_CL_DIG  = 4'd4;
	localparam logic [3:0] PH_CL_TAIL = 4'd5;
	localparam logic [3:0] PH_LF_NEXT = 4'd6;
	localparam logic [3:0] PH_LF_END  = 4'd7;

	logic [3:0]                         phase_q;
	logic [LINE_W-1:0]                  line_len_q;
	logic [TOT_W-1:0]                   total_q;
	logic [2:0]                         flags_q;
	logic [hrhc_pkg::LEN_W-1:0]         value_q;
	logic                               seen_q;
	logic [hrhc_pkg::VERDICT_W-1:0]     verdict_q;

	logic [3:0]                         c_phase, n_phase;
	logic [LINE_W-1:0]                  c_len, n_len;
	logic [TOT_W-1:0]                   c_tot, n_tot;
	logic [2:0]                         c_flags, n_flags;
	logic [hrhc_pkg::LEN_W-1:0]         c_value, n_value;
	logic                               c_seen, n_seen;
	logic [hrhc_pkg::VERDICT_W-1:0]     c_verdict, n_verdict;

	logic [7:0]                         lc;
	logic [4:0]                         pos5;
	logic                               short_pos;
	logic                               is_digit;
	logic                               is_blank;
	logic                               ok;
	logic [PROD_W-1:0]                  digit_sum;
	logic                               digit_ok;

	// State as seen by this byte: a restart clears it first.
	always_comb begin
		if (restart) begin
			c_phase   = PH_STATUS;
			c_len     = '0;
			c_tot     = '0;
			c_flags   = 3'b111;
			c_value   = '0;
			c_seen    = 1'b0;
			c_verdict = hrhc_pkg::V_BUSY;
		end else begin
			c_phase   = phase_q;
			c_len     = line_len_q;
			c_tot     = total_q;
			c_flags   = flags_q;
			c_value   = value_q;
			c_seen    = seen_q;
			c_verdict = verdict_q;
		end
	end

	// Byte classes and the candidate content length with this digit added.
	always_comb begin
		lc = data_byte;
		if (data_byte >= hrhc_pkg::CH_UPA && data_byte <= hrhc_pkg::CH_UPZ) begin
			lc = data_byte + 8'd32;
		end
		short_pos = ((c_len >> 5) == '0);
		pos5      = c_len[4:0];
		is_digit  = (data_byte >= hrhc_pkg::CH_ZERO) && (data_byte <= hrhc_pkg::CH_NINE);
		is_blank  = (data_byte == hrhc_pkg::CH_SP) || (data_byte == hrhc_pkg::CH_TAB);
		digit_sum = ({4'b0, c_value} << 3) + ({4'b0, c_value} << 1)
			+ PROD_W'(data_byte[3:0]);
		digit_ok  = (digit_sum <= {4'b0, length_limit})
			&& (digit_sum <= {4'b0, expected_length});
	end

	// Next state for one byte.
	always_comb begin
		n_phase   = c_phase;
		n_len     = c_len;
		n_tot     = c_tot;
		n_flags   = c_flags;
		n_value   = c_value;
		n_seen    = c_seen;
		n_verdict = c_verdict;
		ok        = 1'b1;
		if (c_verdict == hrhc_pkg::V_BUSY) begin
			n_tot = c_tot + TOT_W'(1);
			if (n_tot > TOT_W'(MAX_HEADER)) begin
				n_verdict = hrhc_pkg::V_REJECT;
			end else if (c_phase == PH_LF_NEXT || c_phase == PH_LF_END) begin
				// A CR must be followed by LF.
				if (data_byte != hrhc_pkg::CH_LF) begin
					n_verdict = hrhc_pkg::V_REJECT;
				end else if (c_phase == PH_LF_END) begin
					n_verdict = hrhc_pkg::V_ACCEPT;
				end else begin
					n_phase = PH_NAME;
					n_len   = '0;
					n_flags = 3'b111;
				end
			end else if (data_byte == hrhc_pkg::CH_CR) begin
				// End of line.
				case (c_phase)
					PH_STATUS: begin
						if (c_len < LINE_W'(12)) begin
							ok = 1'b0;
						end
						n_phase = PH_LF_NEXT;
					end
					PH_NAME: begin
						if (c_len != '0 || !c_seen) begin
							ok = 1'b0;
						end
						n_phase = PH_LF_END;
					end
					PH_OTHER: begin
						n_phase = PH_LF_NEXT;
					end
					PH_CL_DIG, PH_CL_TAIL: begin
						if (c_value == '0 || c_value != expected_length) begin
							ok = 1'b0;
						end
						n_seen  = 1'b1;
						n_phase = PH_LF_NEXT;
					end
					default: begin
						ok = 1'b0;
					end
				endcase
				if (!ok) begin
					n_verdict = hrhc_pkg::V_REJECT;
				end
			end else if (data_byte == hrhc_pkg::CH_LF || data_byte == hrhc_pkg::CH_NUL
				|| c_len >= LINE_W'(MAX_LINE)) begin
				n_verdict = hrhc_pkg::V_REJECT;
			end else begin
				// Ordinary byte inside a line.
				case (c_phase)
					PH_STATUS: begin
						if (c_len == LINE_W'(7)) begin
							ok = (data_byte == hrhc_pkg::CH_ZERO)
								|| (data_byte == hrhc_pkg::CH_ONE);
						end else if (c_len <= LINE_W'(12)) begin
							ok = (data_byte == hrhc_pkg::status_at(c_len[3:0]));
						end
					end
					PH_NAME: begin
						if (data_byte == hrhc_pkg::CH_COLON) begin
							if (c_len == '0) begin
								ok = 1'b0;
							end else if ((c_flags[0] && c_len == LINE_W'(17))
								|| (c_flags[1] && c_len == LINE_W'(16))) begin
								ok = 1'b0;
							end else if (c_flags[2] && c_len == LINE_W'(14)) begin
								ok      = !c_seen;
								n_value = '0;
								n_phase = PH_CL_LEAD;
							end else begin
								n_phase = PH_OTHER;
							end
						end else if (data_byte <= hrhc_pkg::CH_SP
							|| data_byte >= hrhc_pkg::CH_DEL) begin
							ok = 1'b0;
						end else begin
							n_flags[0] = c_flags[0] && short_pos
								&& (lc == hrhc_pkg::te_at(pos5));
							n_flags[1] = c_flags[1] && short_pos
								&& (lc == hrhc_pkg::ce_at(pos5));
							n_flags[2] = c_flags[2] && short_pos
								&& (lc == hrhc_pkg::cl_at(pos5));
						end
					end
					PH_OTHER: begin
						ok = 1'b1;
					end
					PH_CL_LEAD: begin
						if (is_digit) begin
							n_phase = PH_CL_DIG;
							ok      = digit_ok;
							n_value = digit_sum[hrhc_pkg::LEN_W-1:0];
						end else begin
							ok = is_blank;
						end
					end
					PH_CL_DIG: begin
						if (is_digit) begin
							ok      = digit_ok;
							n_value = digit_sum[hrhc_pkg::LEN_W-1:0];
						end else if (is_blank) begin
							n_phase = PH_CL_TAIL;
						end else begin
							ok = 1'b0;
						end
					end
					PH_CL_TAIL: begin
						ok = is_blank;
					end
					default: begin
						ok = 1'b0;
					end
				endcase
				if (ok) begin
					n_len = c_len + LINE_W'(1);
				end else begin
					n_verdict = hrhc_pkg::V_REJECT;
				end
			end
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_STATUS;
			line_len_q <= '0;
			total_q    <= '0;
			flags_q    <= 3'b111;
			value_q    <= '0;
			seen_q     <= 1'b0;
			verdict_q  <= hrhc_pkg::V_BUSY;
		end else if (step_en) begin
			phase_q    <= n_phase;
			line_len_q <= n_len;
			total_q    <= n_tot;
			flags_q    <= n_flags;
			value_q    <= n_value;
			seen_q     <= n_seen;
			verdict_q  <= n_verdict;
		end
	end

	assign verdict_cur  = c_verdict;
	assign verdict_next = n_verdict;

endmodule

### hw/rtl/http_response_header_checker.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   restart, data_byte
// output    out        out_valid / out_stall verdict
// config    in         cfg_we                cfg_index, cfg_data
//
// One byte per cycle is accepted while in_stall is low; each byte gives one verdict.
// The byte register feeds the parse logic, which updates the parse state and the
// verdict register in the same cycle; unstalled, throughput is one transaction a cycle.
// in_stall rises only while a verdict waits in the output register and out_stall is high.
// Reset clears the parse state, valid bits and expected_q, and sets limit_q to all ones.
module http_response_header_checker #(
	parameter int unsigned MAX_LINE   = hrhc_pkg::MAX_LINE_DEF,
	parameter int unsigned MAX_HEADER = hrhc_pkg::MAX_HEADER_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            restart,
	input  logic [7:0]                      data_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [hrhc_pkg::VERDICT_W-1:0]  verdict,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [hrhc_pkg::LEN_W-1:0]      cfg_data
);

	logic                               valid_s1;
	logic                               restart_s1;
	logic [7:0]                         byte_s1;
	logic                               out_valid_q;
	logic [hrhc_pkg::VERDICT_W-1:0]     verdict_q;
	logic [hrhc_pkg::LEN_W-1:0]         expected_q;
	logic [hrhc_pkg::LEN_W-1:0]         limit_q;
	logic                               advance;
	logic                               step_en;
	logic [hrhc_pkg::VERDICT_W-1:0]     verdict_cur;
	logic [hrhc_pkg::VERDICT_W-1:0]     verdict_next;

	// The byte stage moves on whenever the output register is free or being read.
	assign advance  = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
			limit_q    <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				hrhc_pkg::CFG_EXPECTED: expected_q <= cfg_data;
				hrhc_pkg::CFG_LIMIT:    limit_q    <= cfg_data;
				default:                expected_q <= expected_q;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			restart_s1 <= restart;
			byte_s1    <= data_byte;
		end
	end

	hrhc_core #(
		.MAX_LINE   (MAX_LINE),
		.MAX_HEADER (MAX_HEADER)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (step_en),
		.restart         (restart_s1),
		.data_byte       (byte_s1),
		.expected_length (expected_q),
		.length_limit    (limit_q),
		.verdict_cur     (verdict_cur),
		.verdict_next    (verdict_next)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			verdict_q <= verdict_next;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

`ifndef NO_ASSERTIONS
	// The input side waits only behind a result that is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	// Every byte that is parsed leaves a result in the output register.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> out_valid_q)
		else $error("parsed byte produced no result");

	// A final verdict holds until a restart.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && !restart_s1 && verdict_cur != hrhc_pkg::V_BUSY)
		|-> (verdict_next == verdict_cur))
		else $error("final verdict changed without restart");
`endif

endmodule

### dv/tb_http_response_header_checker.sv
`timescale 1ns / 1ps

module tb_http_response_header_checker;
	import hrhc_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned RANDOM_BYTES = 700;
	localparam int unsigned CALM_BYTES   = 150;
	localparam int unsigned HOLD_CYCLES  = 40;
	localparam logic [LEN_W-1:0] MAX_LEN = '1;

	// Parse phases of the predictor.
	typedef enum logic [3:0] {
		PS_STATUS, PS_NAME, PS_OTHER, PS_CL_LEAD, PS_CL_DIGIT, PS_CL_TAIL,
		PS_WANT_LF, PS_WANT_LF_END
	} phase_t;

	// Bits of the header name candidate flags.
	localparam int TE_BIT = 0;
	localparam int CE_BIT = 1;
	localparam int CL_BIT = 2;

	typedef struct packed {
		logic       restart;
		logic [7:0] data;
	} rx_byte_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic                 restart   = 1'b0;
	logic [7:0]           data_byte = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [VERDICT_W-1:0] verdict;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_index = 1'b0;
	logic [LEN_W-1:0]     cfg_data  = '0;

	// Predictor copy of the configuration, at reset values.
	logic [LEN_W-1:0] expected_len = '0;
	logic [LEN_W-1:0] length_max   = '1;

	// Predictor copy of the parse state.
	phase_t               phase;
	int unsigned          line_len;
	int unsigned          hdr_total;
	logic [2:0]           name_flags;
	logic [LEN_W-1:0]     cl_value;
	logic                 cl_seen;
	logic [VERDICT_W-1:0] parse_verdict;

	string status_text = "HTTP/1.x 200 ";
	string te_name     = "transfer-encoding";
	string ce_name     = "content-encoding";
	string cl_name     = "content-length";

	rx_byte_t             response_bytes[$];
	logic                 next_restart = 1'b0;
	logic [VERDICT_W-1:0] pending_verdicts[$];
	logic [VERDICT_W-1:0] head_verdict;

	bit          in_gaps_on    = 1'b0;
	bit          out_stalls_on = 1'b0;
	int unsigned hold_request  = 0;
	int unsigned hold_left     = 0;
	int unsigned burst_left    = 0;

	int unsigned cycle_count    = 0;
	int unsigned error_count    = 0;
	int unsigned verdicts_seen  = 0;
	int unsigned parsed_bytes   = 0;
	int unsigned accepted_count = 0;
	int unsigned rejected_count = 0;
	int unsigned stalled_cycles = 0;

	http_response_header_checker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.restart   (restart),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.verdict   (verdict),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (in_stall) begin
			stalled_cycles++;
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d verdicts outstanding.", cycle_count,
				pending_verdicts.size());
			$display("tb_http_response_header_checker NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_parse();
		phase         = PS_STATUS;
		line_len      = 0;
		hdr_total     = 0;
		name_flags    = 3'b111;
		cl_value      = '0;
		cl_seen       = 1'b0;
		parse_verdict = V_BUSY;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// Appends a digit to the length; a clear bit means no continuation can pass.
	function automatic bit add_digit(input logic [7:0] c);
		int unsigned v;
		v = cl_value;
		if (v > length_max / 10) begin
			return 1'b0;
		end
		v = v * 10 + (c - CH_ZERO);
		if (v > length_max || v > expected_len) begin
			return 1'b0;
		end
		cl_value = v[LEN_W-1:0];
		return 1'b1;
	endfunction

	// A CR closes the current line.
	function automatic bit close_line();
		case (phase)
			PS_STATUS: begin
				if (line_len < 12) begin
					return 1'b0;
				end
				phase = PS_WANT_LF;
				return 1'b1;
			end
			PS_NAME: begin
				if (line_len != 0 || !cl_seen) begin
					return 1'b0;
				end
				phase = PS_WANT_LF_END;
				return 1'b1;
			end
			PS_OTHER: begin
				phase = PS_WANT_LF;
				return 1'b1;
			end
			PS_CL_DIGIT, PS_CL_TAIL: begin
				if (cl_value == 0 || cl_value != expected_len) begin
					return 1'b0;
				end
				cl_seen = 1'b1;
				phase   = PS_WANT_LF;
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	// An ordinary byte inside a line.
	function automatic bit line_byte_ok(input logic [7:0] c);
		int unsigned pos;
		logic [7:0]  lc;
		pos = line_len;
		case (phase)
			PS_STATUS: begin
				if (pos == 7) begin
					return c == CH_ZERO || c == CH_ONE;
				end
				if (pos <= 12) begin
					return status_text[pos] == c;
				end
				return 1'b1;
			end
			PS_NAME: begin
				if (c == CH_COLON) begin
					if (pos == 0) begin
						return 1'b0;
					end
					if ((name_flags[TE_BIT] && pos == 17) || (name_flags[CE_BIT] && pos == 16)) begin
						return 1'b0;
					end
					if (name_flags[CL_BIT] && pos == 14) begin
						if (cl_seen) begin
							return 1'b0;
						end
						cl_value = '0;
						phase    = PS_CL_LEAD;
					end else begin
						phase = PS_OTHER;
					end
					return 1'b1;
				end
				if (c <= CH_SP || c >= CH_DEL) begin
					return 1'b0;
				end
				lc = (c >= CH_UPA && c <= CH_UPZ) ? c + 8'd32 : c;
				name_flags &= {(pos < 14) && (cl_name[pos] == lc),
					(pos < 16) && (ce_name[pos] == lc),
					(pos < 17) && (te_name[pos] == lc)};
				return 1'b1;
			end
			PS_OTHER: begin
				return 1'b1;
			end
			PS_CL_LEAD: begin
				if (is_blank(c)) begin
					return 1'b1;
				end
				if (!is_digit(c)) begin
					return 1'b0;
				end
				phase = PS_CL_DIGIT;
				return add_digit(c);
			end
			PS_CL_DIGIT: begin
				if (is_digit(c)) begin
					return add_digit(c);
				end
				if (is_blank(c)) begin
					phase = PS_CL_TAIL;
					return 1'b1;
				end
				return 1'b0;
			end
			PS_CL_TAIL: begin
				return is_blank(c);
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	function automatic logic [VERDICT_W-1:0] take_byte(input logic [7:0] c);
		hdr_total++;
		if (hdr_total > MAX_HEADER_DEF) begin
			return V_REJECT;
		end
		if (phase == PS_WANT_LF || phase == PS_WANT_LF_END) begin
			if (c != CH_LF) begin
				return V_REJECT;
			end
			if (phase == PS_WANT_LF_END) begin
				return V_ACCEPT;
			end
			phase      = PS_NAME;
			line_len   = 0;
			name_flags = 3'b111;
			return V_BUSY;
		end
		if (c == CH_CR) begin
			return close_line() ? V_BUSY : V_REJECT;
		end
		if (c == CH_LF || c == CH_NUL || line_len >= MAX_LINE_DEF) begin
			return V_REJECT;
		end
		if (!line_byte_ok(c)) begin
			return V_REJECT;
		end
		line_len++;
		return V_BUSY;
	endfunction

	// The verdict is sticky until a byte with restart set.
	function automatic logic [VERDICT_W-1:0] predict_verdict(input logic rst, input logic [7:0] c);
		if (rst) begin
			clear_parse();
		end
		if (parse_verdict == V_BUSY) begin
			parse_verdict = take_byte(c);
		end
		return parse_verdict;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what);
		if (error_count < 30) begin
			$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		end
		error_count++;
	endtask

	// Each verdict transaction is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			verdicts_seen++;
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("verdict %0d with none predicted", verdict));
			end else begin
				head_verdict = pending_verdicts.pop_front();
				if (verdict !== head_verdict) begin
					report_mismatch($sformatf("verdict %0d, predicted %0d", verdict, head_verdict));
				end
			end
		end
	end

	// Receiver: long hold-offs on request, otherwise random stall bursts.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (burst_left != 0) begin
			burst_left--;
			out_stall <= 1'b1;
		end else if (out_stalls_on && $urandom_range(0, 5) == 0) begin
			burst_left = $urandom_range(0, 5);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- sending

	// Sends one byte; the prediction is made when the transaction is accepted.
	task automatic send_item(input rx_byte_t rb);
		logic [VERDICT_W-1:0] want;
		bit                   was_busy;
		if (in_gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		restart   <= rb.restart;
		data_byte <= rb.data;
		do @(posedge clk); while (in_stall);
		was_busy = rb.restart || parse_verdict == V_BUSY;
		want     = predict_verdict(rb.restart, rb.data);
		if (was_busy) begin
			parsed_bytes++;
			if (want == V_ACCEPT) begin
				accepted_count++;
			end
			if (want == V_REJECT) begin
				rejected_count++;
			end
		end
		pending_verdicts.push_back(want);
	endtask

	task automatic send_pending();
		foreach (response_bytes[i]) begin
			send_item(response_bytes[i]);
		end
		response_bytes.delete();
	endtask

	// Drops valid, then waits until every predicted verdict has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Both registers are written back to back while the block is idle.
	task automatic program_lengths(input logic [LEN_W-1:0] exp_value,
		input logic [LEN_W-1:0] lim_value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_EXPECTED;
		cfg_data  <= exp_value;
		@(posedge clk);
		cfg_index <= CFG_LIMIT;
		cfg_data  <= lim_value;
		@(posedge clk);
		cfg_we <= 1'b0;
		expected_len = exp_value;
		length_max   = lim_value;
	endtask

	// ---------------------------------------------------------------- text building

	function automatic void new_response();
		next_restart = 1'b1;
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		response_bytes.push_back('{restart: next_restart, data: b});
		next_restart = 1'b0;
	endfunction

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			put_byte(s[i]);
		end
	endfunction

	function automatic void put_line(input string s);
		put_text(s);
		put_byte(CH_CR);
		put_byte(CH_LF);
	endfunction

	function automatic void put_status();
		put_line("HTTP/1.1 200 OK");
	endfunction

	// Header lines of filler adding up to the given number of bytes.
	function automatic void put_padding(input int unsigned total);
		int unsigned left;
		int unsigned chunk;
		string       s;
		left = total;
		while (left != 0) begin
			chunk = (left > 255) ? 200 : left;
			s = "X: ";
			repeat (chunk - 5) s = {s, "p"};
			put_line(s);
			left -= chunk;
		end
	endfunction

	function automatic string mixed_case(input string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++) begin
			if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1) == 1) begin
				r[i] = r[i] - 8'd32;
			end
		end
		return r;
	endfunction

	// Printable characters; name characters exclude blank and colon.
	function automatic string random_chars(input int unsigned min_len, input int unsigned max_len,
		input bit name_chars);
		string       s;
		int unsigned n;
		byte         b;
		s = "";
		n = $urandom_range(min_len, max_len);
		for (int i = 0; i < n; i++) begin
			b = name_chars ? $urandom_range(33, 126) : $urandom_range(32, 126);
			if (name_chars && b == CH_COLON) begin
				b = "_";
			end
			s = {s, " "};
			s[s.len() - 1] = b;
		end
		return s;
	endfunction

	function automatic string blanks(input int unsigned n);
		string s;
		s = "";
		repeat (n) s = {s, ($urandom_range(0, 1) == 1) ? "\t" : " "};
		return s;
	endfunction

	function automatic void put_length_line();
		logic [LEN_W-1:0] v;
		string            s;
		case ($urandom_range(0, 9))
			0: v = expected_len + 1;
			1: v = expected_len - 1;
			2: v = $urandom();
			default: v = expected_len;
		endcase
		s = {mixed_case("content-length"), ":", blanks($urandom_range(0, 2))};
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) s = {s, "0"};
		end
		s = {s, $sformatf("%0d", v), blanks($urandom_range(0, 2))};
		put_line(s);
	endfunction

	function automatic void put_other_header();
		string name;
		case ($urandom_range(0, 15))
			0: name = mixed_case("transfer-encoding");
			1: name = mixed_case("content-encoding");
			2: name = {mixed_case("content-length"), random_chars(1, 2, 1'b1)};
			default: name = random_chars(1, 12, 1'b1);
		endcase
		put_line({name, ":", random_chars(0, 20, 1'b0)});
	endfunction

	// A response with random status text and headers, not always valid, then a few body bytes.
	function automatic void put_random_response();
		int unsigned n_hdr;
		int unsigned cl_slot;
		string       s;
		new_response();
		s = $sformatf("HTTP/1.%0d 200", $urandom_range(0, 1));
		if ($urandom_range(0, 1) == 1) begin
			s = {s, " ", random_chars(1, 8, 1'b0)};
		end
		put_line(s);
		n_hdr   = $urandom_range(0, 3);
		cl_slot = ($urandom_range(0, 11) == 0) ? n_hdr + 1 : $urandom_range(0, n_hdr);
		for (int i = 0; i <= n_hdr; i++) begin
			if (i == cl_slot) begin
				put_length_line();
			end else begin
				put_other_header();
			end
		end
		put_line("");
		put_text(random_chars(0, 4, 1'b0));
	endfunction

	// Breaks some responses: a random byte, a restart midway, or a cut.
	function automatic void roughen_response();
		int unsigned k;
		if (response_bytes.size() < 2) begin
			return;
		end
		k = $urandom_range(1, response_bytes.size() - 1);
		case ($urandom_range(0, 9))
			0, 1: response_bytes[k].data = $urandom_range(0, 255);
			2: response_bytes[k].restart = 1'b1;
			3: response_bytes = response_bytes[0:k];
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	// Reset values: expected length 0 refuses every content-length.
	task automatic test_reset_defaults();
		new_response();
		put_status();
		put_line("Content-Length: 0");
		put_line("");
		new_response();
		put_line("HTTP/1.0 200");
		put_line("");
		put_text("xx");
		new_response();
		put_line("HTTP/1.1 200");
		put_line("Content-Length: 1");
		send_pending();
	endtask

	// Accepting responses, sticky verdicts and a restart in mid-header.
	task automatic test_accept_paths();
		program_lengths(24'd5, MAX_LEN);
		new_response();
		put_status();
		put_line("Server: unit");
		put_line("Content-Length: 5");
		put_line("");
		put_text("hello");
		new_response();
		put_line("HTTP/1.0 200");
		put_line({"CONTENT-length:\t 5 \t"});
		put_line("X-Note: a:b:c");
		put_line("");
		new_response();
		put_status();
		put_text("Content-Len");
		new_response();
		put_line("HTTP/1.1 200 Fine");
		put_line("content-length:5");
		put_line("");
		put_text("more");
		send_pending();
	endtask

	task automatic test_status_line();
		new_response();
		put_line("HTTP/1.2 200");
		new_response();
		put_line("http/1.1 200");
		new_response();
		put_line("HTTP/1.1 201");
		new_response();
		put_line("HTTP/1.1 2000");
		new_response();
		put_line("HTTP/1.1 20");
		new_response();
		put_line("HTTP/1.0");
		send_pending();
	endtask

	task automatic test_header_names();
		new_response();
		put_status();
		put_line("Transfer-Encoding: chunked");
		new_response();
		put_status();
		put_line("content-encoding: gzip");
		new_response();
		put_status();
		put_line("transfer-encodingX: 1");
		put_line("Content-Encodin: x");
		put_line("Content-Lengths: 9");
		put_line("Content-Length: 5");
		put_line("");
		new_response();
		put_status();
		put_line("Content-Length: 5");
		put_line("content-length: 5");
		new_response();
		put_status();
		put_line(": value");
		new_response();
		put_status();
		put_line("Bad Name: x");
		new_response();
		put_status();
		put_text("Ba");
		put_byte(CH_DEL);
		put_line("d: 1");
		new_response();
		put_status();
		put_text("Ba");
		put_byte(8'hFF);
		put_line("d: 1");
		new_response();
		put_status();
		put_byte(8'h01);
		put_line("d: 1");
		new_response();
		put_status();
		put_line("NoColon");
		send_pending();
	endtask

	task automatic test_length_field();
		string bad_values[$];
		bad_values = '{"6", "4", "0", "5x", "", "5 6", "-5", "+5"};
		foreach (bad_values[i]) begin
			new_response();
			put_status();
			put_line({"Content-Length: ", bad_values[i]});
			put_line("");
		end
		new_response();
		put_status();
		put_line("Content-Length:x");
		new_response();
		put_status();
		put_line("Content-Length: 0005");
		put_line("");
		// An empty line with no content-length.
		new_response();
		put_status();
		put_line("Server: unit");
		put_line("");
		send_pending();
	endtask

	task automatic test_bad_bytes();
		new_response();
		put_text("HTTP/1.1 200");
		put_byte(CH_CR);
		put_text("X");
		new_response();
		put_status();
		put_text("Server: a");
		put_byte(CH_NUL);
		put_line("");
		new_response();
		put_status();
		put_text("Server: a");
		put_byte(CH_LF);
		new_response();
		put_text("HTTP");
		put_byte(CH_NUL);
		send_pending();
	endtask

	// Line and header size limits, each just inside and just past.
	task automatic test_size_limits();
		string s;
		s = "HTTP/1.1 200 ";
		repeat (MAX_LINE_DEF - 13) s = {s, "A"};
		new_response();
		put_line(s);
		put_line("Content-Length: 5");
		put_line("");
		new_response();
		put_text(s);
		put_text("A");
		put_line("");
		// Status, length and empty line take 38 bytes.
		new_response();
		put_status();
		put_padding(MAX_HEADER_DEF - 38);
		put_line("Content-Length: 5");
		put_line("");
		new_response();
		put_status();
		put_padding(MAX_HEADER_DEF - 37);
		put_line("Content-Length: 5");
		put_line("");
		send_pending();
	endtask

	// Each group of responses is sent under its own register values.
	task automatic test_register_extremes();
		program_lengths(24'd1, '0);
		new_response();
		put_status();
		put_line("Content-Length: 1");
		new_response();
		put_status();
		put_line("Content-Length: 0");
		put_line("");
		send_pending();
		program_lengths(24'd1, 24'd1);
		new_response();
		put_status();
		put_line("Content-Length: 01");
		put_line("");
		send_pending();
		program_lengths(MAX_LEN, MAX_LEN);
		new_response();
		put_status();
		put_line("Content-Length: 16777215");
		put_line("");
		new_response();
		put_status();
		put_line("Content-Length: 16777216");
		new_response();
		put_status();
		put_line("Content-Length: 167772150");
		send_pending();
		program_lengths(24'd200, 24'd100);
		new_response();
		put_status();
		put_line("Content-Length: 200");
		new_response();
		put_status();
		put_line("Content-Length: 1000");
		send_pending();
		program_lengths(24'd100, 24'd100);
		new_response();
		put_status();
		put_line("Content-Length: 100");
		put_line("");
		send_pending();
	endtask

	// The receiver holds off while bytes keep coming, so the block fills up.
	task automatic test_backpressure();
		bit gaps_saved;
		gaps_saved = in_gaps_on;
		program_lengths(24'd12, MAX_LEN);
		in_gaps_on   = 1'b0;
		hold_request = HOLD_CYCLES;
		new_response();
		put_status();
		put_line("Content-Type: text/plain");
		put_line("Content-Length: 12");
		put_line("");
		put_text("hello world!");
		send_pending();
		wait_idle();
		hold_request = HOLD_CYCLES;
		new_response();
		put_status();
		put_line("Content-Length: 13");
		put_text("trailing bytes that are ignored");
		send_pending();
		in_gaps_on = gaps_saved;
	endtask

	task automatic program_random_lengths();
		logic [LEN_W-1:0] e;
		logic [LEN_W-1:0] l;
		case ($urandom_range(0, 3))
			0: e = $urandom_range(1, 9);
			1: e = $urandom_range(10, 99999);
			2: e = $urandom();
			default: e = MAX_LEN;
		endcase
		case ($urandom_range(0, 3))
			0: l = e;
			1: l = e + $urandom_range(1, 1000);
			2: l = $urandom();
			default: l = MAX_LEN;
		endcase
		program_lengths(e, l);
	endtask

	task automatic test_random_traffic(input int unsigned byte_goal);
		int unsigned target;
		int unsigned count;
		target = parsed_bytes + byte_goal;
		count  = 0;
		while (parsed_bytes < target) begin
			if (count % 6 == 0) begin
				program_random_lengths();
			end
			put_random_response();
			roughen_response();
			send_pending();
			count++;
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		clear_parse();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		in_gaps_on    = 1'b1;
		out_stalls_on = 1'b1;
		test_reset_defaults();
		test_accept_paths();
		test_status_line();
		test_header_names();
		test_length_field();
		test_bad_bytes();
		test_size_limits();
		test_register_extremes();
		test_backpressure();
		test_random_traffic(RANDOM_BYTES - CALM_BYTES);
		// Last stretch at full rate on both sides.
		in_gaps_on    = 1'b0;
		out_stalls_on = 1'b0;
		test_random_traffic(CALM_BYTES);
		wait_idle();
		$display("Parsed %0d header bytes: %0d responses accepted, %0d rejected.",
			parsed_bytes, accepted_count, rejected_count);
		$display("Compared %0d verdicts; input held off on %0d cycles; %0d mismatches.",
			verdicts_seen, stalled_cycles, error_count);
		if (error_count == 0) begin
			$display("tb_http_response_header_checker OK");
		end else begin
			$display("tb_http_response_header_checker NOT OK");
		end
		$finish;
	end

endmodule
